// File: hdl/shift_add_graph_evaluator_unit_defines.svh
// Assertion macros for the shift-add graph evaluator.
`ifndef SHIFT_ADD_GRAPH_EVALUATOR_UNIT_DEFINES_SVH
`define SHIFT_ADD_GRAPH_EVALUATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checked property, ignored while rst is high.
`define SAGE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checked property that also holds through reset.
`define SAGE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SAGE_ASSERT(lbl, prop, msg)
`define SAGE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: hdl/sage_pkg.sv
// Types and constants shared by the shift-add graph evaluator files.
package sage_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int VALUE_BITS  = 32;
  localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
  localparam int COUNT_BITS  = $clog2(TABLE_DEPTH + 1);
  localparam int INDEX_BITS  = 7;
  localparam int SHIFT_BITS  = 7;
  localparam int SHIFT_LIMIT = 64;
  localparam int CMP_BITS    = (INDEX_BITS > COUNT_BITS) ? INDEX_BITS : COUNT_BITS;

  localparam int IN_FIELD_BITS  = 2 * INDEX_BITS + 2 * SHIFT_BITS + 2;
  localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_FIRST_NEG = 3'd1,
    STATUS_BAD_INDEX = 3'd2,
    STATUS_OVERFLOW  = 3'd3,
    STATUS_FULL      = 3'd4,
    STATUS_ABORTED   = 3'd5
  } status_t;

  // Last member sits in the lowest bits, matching the tdata layout.
  typedef struct packed {
    logic                  second_negated;
    logic [SHIFT_BITS-1:0] second_shift;
    logic [INDEX_BITS-1:0] second_index;
    logic                  first_negated;
    logic [SHIFT_BITS-1:0] first_shift;
    logic [INDEX_BITS-1:0] first_index;
  } node_t;

  typedef struct packed {
    status_t               status;
    logic [ADDR_BITS-1:0]  node_number;
    logic [VALUE_BITS-1:0] node_value;
  } result_t;

  localparam int OUT_FIELD_BITS = $bits(result_t);
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

endpackage

// File: hdl/shift_add_graph_evaluator_unit.sv
// Top level of the shift-add graph evaluator.
//
// Evaluates an adder graph one node per beat: each input beat names two
// earlier table entries with a left shift each and yields one result beat
// with the new value (sum, or absolute difference when the second link is
// negated), the table slot it went to and a status code. Throughput is one
// beat per clock while the output is not stalled. On acceptance the table
// is read into the node register, and the result register loads the result
// as the node leaves the node register, unless the output is stalled.
// The 64 x 32 value table is a RAM with two registered read
// ports read as the beat is accepted; a value produced by the node just
// ahead is bypassed around the RAM so dependent nodes run back to back.
// Entry 0 always reads as 1. After any error the rest of the program
// returns status aborted; the beat with tlast set ends the program and the
// table starts over with one entry. No clearing pass is needed after reset.
`include "shift_add_graph_evaluator_unit_defines.svh"

module shift_add_graph_evaluator_unit (
  input  logic                                clk,
  input  logic                                rst,
  // node in
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // first_index, first_shift, first_negated, second_index, second_shift,
  // second_negated (low bit up), zero padded
  input  logic [sage_pkg::IN_TDATA_BITS-1:0]  s_tdata,
  input  logic                                s_tlast,   // last_node
  // result out
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // node_value, node_number, status (low bit up), zero padded
  output logic [sage_pkg::OUT_TDATA_BITS-1:0] m_tdata,
  output logic                                m_tlast    // last_result
);

  logic                            accept;
  logic                            advance;
  logic                            write_en;

  // node register stage
  logic                            s1_valid;
  sage_pkg::node_t                 s1_node;
  logic                            s1_last;
  logic                            fwd_a;
  logic                            fwd_b;
  logic [sage_pkg::VALUE_BITS-1:0] fwd_value;

  sage_pkg::node_t                 in_node;
  logic [sage_pkg::VALUE_BITS-1:0] ram_a;
  logic [sage_pkg::VALUE_BITS-1:0] ram_b;
  logic [sage_pkg::VALUE_BITS-1:0] operand_a;
  logic [sage_pkg::VALUE_BITS-1:0] operand_b;
  sage_pkg::result_t               result;

  // program state
  logic [sage_pkg::COUNT_BITS-1:0] entry_count;
  logic                            aborted;

  assign in_node  = sage_pkg::node_t'(s_tdata[sage_pkg::IN_FIELD_BITS-1:0]);
  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;
  assign accept   = s_tvalid && s_tready;
  assign write_en = advance && (result.status == sage_pkg::STATUS_OK);

  sage_value_ram u_ram (
    .clk     (clk),
    .we      (write_en),
    .waddr   (sage_pkg::ADDR_BITS'(entry_count)),
    .wdata   (result.node_value),
    .re      (accept),
    .raddr_a (sage_pkg::ADDR_BITS'(in_node.first_index)),
    .raddr_b (sage_pkg::ADDR_BITS'(in_node.second_index)),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  // entry 0 is the constant 1; otherwise take the bypass if the node ahead
  // wrote this slot on the accept edge
  always_comb begin
    if (s1_node.first_index == '0) begin
      operand_a = sage_pkg::VALUE_BITS'(1);
    end else if (fwd_a) begin
      operand_a = fwd_value;
    end else begin
      operand_a = ram_a;
    end
    if (s1_node.second_index == '0) begin
      operand_b = sage_pkg::VALUE_BITS'(1);
    end else if (fwd_b) begin
      operand_b = fwd_value;
    end else begin
      operand_b = ram_b;
    end
  end

  sage_node_alu u_alu (
    .node        (s1_node),
    .operand_a   (operand_a),
    .operand_b   (operand_b),
    .entry_count (entry_count),
    .aborted     (aborted),
    .result      (result)
  );

  // node register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_node   <= in_node;
      s1_last   <= s_tlast;
      fwd_a     <= write_en && (sage_pkg::CMP_BITS'(in_node.first_index) ==
                                sage_pkg::CMP_BITS'(entry_count));
      fwd_b     <= write_en && (sage_pkg::CMP_BITS'(in_node.second_index) ==
                                sage_pkg::CMP_BITS'(entry_count));
      fwd_value <= result.node_value;
    end
  end

  // program state advances as a node leaves the node register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= sage_pkg::COUNT_BITS'(1);
      aborted     <= 1'b0;
    end else if (advance) begin
      if (s1_last) begin
        entry_count <= sage_pkg::COUNT_BITS'(1);
        aborted     <= 1'b0;
      end else if (result.status == sage_pkg::STATUS_OK) begin
        entry_count <= entry_count + sage_pkg::COUNT_BITS'(1);
      end else begin
        aborted <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= sage_pkg::OUT_TDATA_BITS'(result);
      m_tlast <= s1_last;
    end
  end

  `SAGE_ASSERT(a_count_range, (entry_count >= sage_pkg::COUNT_BITS'(1)) && (entry_count <= sage_pkg::COUNT_BITS'(sage_pkg::TABLE_DEPTH)), "entry count out of range")
  `SAGE_ASSERT(a_last_restarts, (advance && s1_last) |=> ((entry_count == sage_pkg::COUNT_BITS'(1)) && !aborted), "table not restarted after last node")
  `SAGE_ASSERT(a_error_is_zero, (advance && (result.status != sage_pkg::STATUS_OK)) |=> (m_tdata[sage_pkg::VALUE_BITS+sage_pkg::ADDR_BITS-1:0] == '0), "error result carries data")
  `SAGE_ASSERT(a_ok_has_slot, (advance && (result.status == sage_pkg::STATUS_OK)) |-> (result.node_number != '0), "good node written to slot zero")

endmodule

// File: hdl/sage_value_ram.sv
// Value table: one write port, two registered read ports.
module sage_value_ram (
  input  logic                            clk,
  input  logic                            we,
  input  logic [sage_pkg::ADDR_BITS-1:0]  waddr,
  input  logic [sage_pkg::VALUE_BITS-1:0] wdata,
  input  logic                            re,
  input  logic [sage_pkg::ADDR_BITS-1:0]  raddr_a,
  input  logic [sage_pkg::ADDR_BITS-1:0]  raddr_b,
  output logic [sage_pkg::VALUE_BITS-1:0] rdata_a,
  output logic [sage_pkg::VALUE_BITS-1:0] rdata_b
);

  logic [sage_pkg::VALUE_BITS-1:0] mem [sage_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // old data on a same-address collision; the caller bypasses it
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: hdl/sage_node_alu.sv
// Per-node checks, shifts and add/difference with status priority.
module sage_node_alu (
  input  sage_pkg::node_t                  node,
  input  logic [sage_pkg::VALUE_BITS-1:0]  operand_a,
  input  logic [sage_pkg::VALUE_BITS-1:0]  operand_b,
  input  logic [sage_pkg::COUNT_BITS-1:0]  entry_count,
  input  logic                             aborted,
  output sage_pkg::result_t                result
);

  // returns {overflow, shifted value}
  function automatic logic [sage_pkg::VALUE_BITS:0] shift_checked(
    input logic [sage_pkg::VALUE_BITS-1:0] x,
    input logic [sage_pkg::SHIFT_BITS-1:0] sh
  );
    logic [2*sage_pkg::VALUE_BITS-1:0] wide;
    logic                              ovf;
    wide = {{sage_pkg::VALUE_BITS{1'b0}}, x} << sh;
    ovf  = (sh >= sage_pkg::SHIFT_BITS'(sage_pkg::SHIFT_LIMIT)) ||
           ((x != '0) &&
            ((sh >= sage_pkg::SHIFT_BITS'(sage_pkg::VALUE_BITS)) ||
             (wide[2*sage_pkg::VALUE_BITS-1:sage_pkg::VALUE_BITS] != '0)));
    return {ovf, wide[sage_pkg::VALUE_BITS-1:0]};
  endfunction

  logic [sage_pkg::VALUE_BITS:0]   sh_a;
  logic [sage_pkg::VALUE_BITS:0]   sh_b;
  logic [sage_pkg::VALUE_BITS:0]   sum;
  logic [sage_pkg::VALUE_BITS-1:0] diff;
  logic [sage_pkg::CMP_BITS-1:0]   count_w;
  logic                            bad_index;
  logic                            table_full;

  always_comb begin
    sh_a    = shift_checked(operand_a, node.first_shift);
    sh_b    = shift_checked(operand_b, node.second_shift);
    sum     = {1'b0, sh_a[sage_pkg::VALUE_BITS-1:0]} + {1'b0, sh_b[sage_pkg::VALUE_BITS-1:0]};
    diff    = (sh_a[sage_pkg::VALUE_BITS-1:0] >= sh_b[sage_pkg::VALUE_BITS-1:0]) ?
              sh_a[sage_pkg::VALUE_BITS-1:0] - sh_b[sage_pkg::VALUE_BITS-1:0] :
              sh_b[sage_pkg::VALUE_BITS-1:0] - sh_a[sage_pkg::VALUE_BITS-1:0];
    count_w = sage_pkg::CMP_BITS'(entry_count);
    bad_index = (sage_pkg::CMP_BITS'(node.first_index) >= count_w) ||
                (sage_pkg::CMP_BITS'(node.second_index) >= count_w);
    table_full = (entry_count >= sage_pkg::COUNT_BITS'(sage_pkg::TABLE_DEPTH));

    result.node_value  = '0;
    result.node_number = '0;
    if (aborted) begin
      result.status = sage_pkg::STATUS_ABORTED;
    end else if (node.first_negated) begin
      result.status = sage_pkg::STATUS_FIRST_NEG;
    end else if (bad_index) begin
      result.status = sage_pkg::STATUS_BAD_INDEX;
    end else if (sh_a[sage_pkg::VALUE_BITS] || sh_b[sage_pkg::VALUE_BITS]) begin
      result.status = sage_pkg::STATUS_OVERFLOW;
    end else if (!node.second_negated && sum[sage_pkg::VALUE_BITS]) begin
      result.status = sage_pkg::STATUS_OVERFLOW;
    end else if (table_full) begin
      result.status = sage_pkg::STATUS_FULL;
    end else begin
      result.status      = sage_pkg::STATUS_OK;
      result.node_value  = node.second_negated ? diff : sum[sage_pkg::VALUE_BITS-1:0];
      result.node_number = sage_pkg::ADDR_BITS'(entry_count);
    end
  end

endmodule
